// ===== hdl/rbfu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbfu_pkg
// Shared types for the register bit field unit: operation codes and the
// command and response words carried between the modules.
// ----------------------------------------------------------------------------
package rbfu_pkg;

    // Bit field operation codes
    typedef enum logic [2:0] {
        ACT_TST  = 3'd0,
        ACT_EXTU = 3'd1,
        ACT_CHG  = 3'd2,
        ACT_EXTS = 3'd3,
        ACT_CLR  = 3'd4,
        ACT_FFO  = 3'd5,
        ACT_SET  = 3'd6,
        ACT_INS  = 3'd7
    } act_t;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned POS_W   = 5;   // bit position within a word
    localparam int unsigned WIDTH_W = 6;   // decoded field width, 1..32

    // Command word
    typedef struct packed {
        act_t                      action;
        logic [DATA_W-1:0]         operand;
        logic signed [DATA_W-1:0]  field_offset;
        logic [POS_W-1:0]          field_width;
        logic [DATA_W-1:0]         insert_value;
    } cmd_word_t;

    // Response word
    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              writes_result;
        logic              flag_n;
        logic              flag_z;
    } rsp_word_t;

endpackage

// ===== hdl/rbfu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbfu_cmd_if / rbfu_rsp_if
// Valid/ready channels for bit field commands and their responses.
// ----------------------------------------------------------------------------
interface rbfu_cmd_if import rbfu_pkg::*; ();
    logic                     valid;
    logic                     ready;
    act_t                     action;
    logic [DATA_W-1:0]        operand;
    logic signed [DATA_W-1:0] field_offset;
    logic [POS_W-1:0]         field_width;
    logic [DATA_W-1:0]        insert_value;

    modport source (
        output valid, action, operand, field_offset, field_width, insert_value,
        input  ready
    );
    modport sink (
        input  valid, action, operand, field_offset, field_width, insert_value,
        output ready
    );
endinterface

interface rbfu_rsp_if import rbfu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] result;
    logic              writes_result;
    logic              flag_n;
    logic              flag_z;

    modport source (
        output valid, result, writes_result, flag_n, flag_z,
        input  ready
    );
    modport sink (
        input  valid, result, writes_result, flag_n, flag_z,
        output ready
    );
endinterface

// ===== hdl/register_bit_field_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_bit_field_unit
// Bit field instruction execution on a 32-bit data register (register forms).
// ----------------------------------------------------------------------------
// The unit takes one command word per clock and returns one response word per
// command, in order. The command is captured in an input register, the rotate,
// mask, leading zero count and offset add run in one combinational pass, and
// the response lands in an output register, from which it is presented once
// the word has moved on from the input register. Sustained throughput is one
// word per cycle; the command side keeps accepting while a finished response
// waits for its consumer, and stalls only when both registers hold words and
// the consumer is not ready.
// ----------------------------------------------------------------------------
module register_bit_field_unit import rbfu_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    rbfu_cmd_if.sink   cmd,
    rbfu_rsp_if.source rsp
);

    logic      s1_valid_reg, s1_valid_next;
    cmd_word_t s1_word_reg;
    logic      out_valid_reg, out_valid_next;
    rsp_word_t out_word_reg;
    rsp_word_t calc;
    cmd_word_t cmd_word;
    logic      out_adv;
    logic      s1_load;

    // pipeline handshake
    assign out_adv   = ~out_valid_reg | rsp.ready;
    assign cmd.ready = ~s1_valid_reg | out_adv;
    assign s1_load   = cmd.valid & cmd.ready;

    assign s1_valid_next  = cmd.ready ? cmd.valid : s1_valid_reg;
    assign out_valid_next = out_adv ? s1_valid_reg : out_valid_reg;

    assign cmd_word.action       = cmd.action;
    assign cmd_word.operand      = cmd.operand;
    assign cmd_word.field_offset = cmd.field_offset;
    assign cmd_word.field_width  = cmd.field_width;
    assign cmd_word.insert_value = cmd.insert_value;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_word_reg <= cmd_word;
        end
        if (out_adv && s1_valid_reg)
        begin
            out_word_reg <= calc;
        end
    end

    // datapath
    rbfu_core u_core (
        .cmd (s1_word_reg),
        .rsp (calc)
    );

    assign rsp.valid         = out_valid_reg;
    assign rsp.result        = out_word_reg.result;
    assign rsp.writes_result = out_word_reg.writes_result;
    assign rsp.flag_n        = out_word_reg.flag_n;
    assign rsp.flag_z        = out_word_reg.flag_z;

    // assertions
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_adv) |=> rsp.valid)
        else $error("staged word not moved to output");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> cmd.ready)
        else $error("empty input stage refuses a word");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !rsp.ready) |-> !cmd.ready)
        else $error("full pipeline accepts a word");

    a_tst_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.writes_result) |-> (rsp.result == '0))
        else $error("test response carries a nonzero result");

endmodule

// ===== hdl/rbfu_lzc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbfu_lzc
// Leading zero count of a 32-bit word as a five step binary normalize.
// An all-zero word reports 31; callers handle that case themselves.
// ----------------------------------------------------------------------------
module rbfu_lzc import rbfu_pkg::*; (
    input  logic [DATA_W-1:0] data,
    output logic [POS_W-1:0]  count
);

    logic [DATA_W-1:0] x16, x8, x4, x2;
    logic [POS_W-1:0]  c;

    // halve the search window each step
    always_comb
    begin
        c[4] = (data[31:16] == 16'd0);
        x16  = c[4] ? (data << 16) : data;
        c[3] = (x16[31:24] == 8'd0);
        x8   = c[3] ? (x16 << 8) : x16;
        c[2] = (x8[31:28] == 4'd0);
        x4   = c[2] ? (x8 << 4) : x8;
        c[1] = (x4[31:30] == 2'd0);
        x2   = c[1] ? (x4 << 2) : x4;
        c[0] = ~x2[31];
    end

    assign count = c;

endmodule

// ===== hdl/rbfu_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbfu_core
// Combinational bit field datapath: rotate the field to the top, build the
// masks, and form the result and N/Z flags for the selected operation.
// ----------------------------------------------------------------------------
module rbfu_core import rbfu_pkg::*; (
    input  cmd_word_t cmd,
    output rsp_word_t rsp
);

    logic [WIDTH_W-1:0]  width;
    logic [WIDTH_W-1:0]  shr_amt;
    logic [POS_W-1:0]    rot;
    logic [DATA_W-1:0]   top_mask;
    logic [DATA_W-1:0]   low_mask;
    logic [DATA_W-1:0]   field;
    logic [DATA_W-1:0]   reg_mask;
    logic [DATA_W-1:0]   ext_u;
    logic [DATA_W-1:0]   ins_val;
    logic [DATA_W-1:0]   ins_top;
    logic [DATA_W-1:0]   ins_place;
    logic [2*DATA_W-1:0] rot_l;
    logic [2*DATA_W-1:0] rot_m;
    logic [2*DATA_W-1:0] rot_i;
    logic [POS_W-1:0]    lz;
    logic [DATA_W-1:0]   ffo_add;
    logic                fld_n;
    logic                fld_z;

    // width code 0 means a full word
    assign width   = (cmd.field_width == '0) ? WIDTH_W'(DATA_W)
                                             : {1'b0, cmd.field_width};
    assign shr_amt = WIDTH_W'(DATA_W) - width;
    assign rot     = cmd.field_offset[POS_W-1:0];

    // masks: shifts by a full word yield zero, so no special case
    assign top_mask = ~({DATA_W{1'b1}} >> width);
    assign low_mask = ~({DATA_W{1'b1}} << width);

    // left-align the field, and place the mask back in register position
    assign rot_l    = {cmd.operand, cmd.operand} << rot;
    assign field    = rot_l[2*DATA_W-1:DATA_W] & top_mask;
    assign rot_m    = {top_mask, top_mask} >> rot;
    assign reg_mask = rot_m[DATA_W-1:0];

    assign fld_n = field[DATA_W-1];
    assign fld_z = (field == '0);
    assign ext_u = field >> shr_amt;

    // insert source, aligned to the top then rotated into place
    assign ins_val   = cmd.insert_value & low_mask;
    assign ins_top   = ins_val << shr_amt;
    assign rot_i     = {ins_top, ins_top} >> rot;
    assign ins_place = rot_i[DATA_W-1:0];

    // find first one
    rbfu_lzc u_lzc (
        .data  (field),
        .count (lz)
    );
    assign ffo_add = fld_z ? DATA_W'(width) : DATA_W'(lz);

    // result select
    always_comb
    begin
        rsp.result        = '0;
        rsp.writes_result = 1'b1;
        rsp.flag_n        = fld_n;
        rsp.flag_z        = fld_z;
        unique case (cmd.action)
            ACT_TST:
            begin
                rsp.writes_result = 1'b0;
            end
            ACT_EXTU: rsp.result = ext_u;
            ACT_CHG:  rsp.result = cmd.operand ^ reg_mask;
            ACT_EXTS: rsp.result = fld_n ? (ext_u | ~low_mask) : ext_u;
            ACT_CLR:  rsp.result = cmd.operand & ~reg_mask;
            ACT_FFO:  rsp.result = cmd.field_offset + ffo_add;
            ACT_SET:  rsp.result = cmd.operand | reg_mask;
            ACT_INS:
            begin
                rsp.result = (cmd.operand & ~reg_mask) | ins_place;
                rsp.flag_n = ins_top[DATA_W-1];
                rsp.flag_z = (ins_val == '0);
            end
            default: rsp.result = '0;
        endcase
    end

endmodule
